FILE: hw/rtl/sfbt_pkg.sv
`timescale 1ns / 1ps

package sfbt_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned COUNT_BITS  = 8;
  localparam int unsigned FRAME_W     = 32;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // fixed widths of the port fields
  localparam int unsigned OUT_IDX_W   = 8;
  localparam int unsigned OUT_CNT_W   = 9;
  localparam int unsigned CMP_W       = (CNT_W > OUT_IDX_W) ? CNT_W : OUT_IDX_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_DUP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_ABSENT = 2'd2,
    STATUS_RANGE  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_RD,
    ST_S_CMP,
    ST_L_RD,
    ST_L_CHK,
    ST_UP_RD,
    ST_UP_WR,
    ST_DN_RD,
    ST_DN_WR,
    ST_DONE
  } state_e;

  // one table entry as stored in memory
  typedef struct packed {
    logic signed [FRAME_W-1:0] frame;
    logic [COUNT_BITS-1:0]     cnt;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // memory access from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // finished result of one operation
  typedef struct packed {
    logic                 found;
    logic [OUT_IDX_W-1:0] found_index;
    logic                 prev_valid;
    logic [OUT_IDX_W-1:0] prev_index;
    logic                 next_valid;
    logic [OUT_IDX_W-1:0] next_index;
    logic                 multiple;
    status_e              status;
    logic [OUT_CNT_W-1:0] entry_count;
  } result_t;

endpackage

FILE: hw/rtl/sfbt_ram.sv
`timescale 1ns / 1ps

module sfbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sfbt_seq.sv
`timescale 1ns / 1ps

module sfbt_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  sfbt_pkg::func_e                      func_i,
  input  logic signed [sfbt_pkg::FRAME_W-1:0]  frame_i,
  input  logic [sfbt_pkg::OUT_IDX_W-1:0]       entry_index_i,
  output logic                                 res_valid_o,
  input  logic                                 res_take_i,
  output sfbt_pkg::result_t                    res_o,
  output sfbt_pkg::mem_req_t                   mem_req_o,
  input  sfbt_pkg::entry_t                     mem_rdata_i
);

  import sfbt_pkg::*;

  state_e                    state_q, state_d;
  func_e                     func_q, func_d;
  logic signed [FRAME_W-1:0] frame_q, frame_d;
  logic [OUT_IDX_W-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]          lo_q, lo_d;
  logic [CNT_W-1:0]          hi_q, hi_d;
  logic [CNT_W-1:0]          ptr_q, ptr_d;
  logic [CNT_W-1:0]          used_q, used_d;
  status_e                   status_q, status_d;
  logic                      mult_q, mult_d;

  logic [CNT_W-1:0]          mid;
  logic [CNT_W-1:0]          lo_inc;
  logic [CNT_W-1:0]          lo_dec;
  logic [CNT_W-1:0]          ptr_inc;
  logic [CNT_W-1:0]          ptr_dec;
  logic                      hit;
  logic                      full;
  logic                      idx_in;
  logic [COUNT_BITS-1:0]     cnt_inc;
  logic [COUNT_BITS-1:0]     cnt_dec;

  // shared arithmetic on the search window and shift pointer
  always_comb begin
    mid     = lo_q + ((hi_q - lo_q) >> 1);
    lo_inc  = lo_q + CNT_W'(1);
    lo_dec  = lo_q - CNT_W'(1);
    ptr_inc = ptr_q + CNT_W'(1);
    ptr_dec = ptr_q - CNT_W'(1);
    hit     = (lo_q < used_q) && (mem_rdata_i.frame == frame_q);
    full    = (used_q == CNT_W'(TABLE_DEPTH));
    idx_in  = (CMP_W'(idx_q) < CMP_W'(used_q));
    cnt_inc = (mem_rdata_i.cnt == COUNT_MAX) ? COUNT_MAX
                                             : mem_rdata_i.cnt + COUNT_BITS'(1);
    cnt_dec = (mem_rdata_i.cnt != '0) ? mem_rdata_i.cnt - COUNT_BITS'(1) : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (func_i == FUNC_DUP) ? ST_L_RD : ST_S_RD;
        end
      end
      ST_S_RD:  state_d = (lo_q < hi_q) ? ST_S_CMP : ST_L_RD;
      ST_S_CMP: state_d = ST_S_RD;
      ST_L_RD:  state_d = ST_L_CHK;
      ST_L_CHK: begin
        case (func_q)
          FUNC_ADD: begin
            state_d = (hit || full) ? ST_DONE : ST_UP_RD;
          end
          FUNC_REMOVE: begin
            state_d = (hit && (cnt_dec == '0)) ? ST_DN_RD : ST_DONE;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_UP_RD: state_d = (ptr_q > lo_q) ? ST_UP_WR : ST_DONE;
      ST_UP_WR: state_d = ST_UP_RD;
      ST_DN_RD: state_d = (ptr_inc < used_q) ? ST_DN_WR : ST_DONE;
      ST_DN_WR: state_d = ST_DN_RD;
      ST_DONE:  state_d = res_take_i ? ST_IDLE : ST_DONE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    func_d    = func_q;
    frame_d   = frame_q;
    idx_d     = idx_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    ptr_d     = ptr_q;
    used_d    = used_q;
    status_d  = status_q;
    mult_d    = mult_q;
    mem_req_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d   = func_i;
          frame_d  = frame_i;
          idx_d    = entry_index_i;
          lo_d     = '0;
          hi_d     = used_q;
          status_d = STATUS_OK;
          mult_d   = 1'b0;
        end
      end
      // binary search for the lower bound
      ST_S_RD: begin
        mem_req_o.raddr = mid[IDX_W-1:0];
      end
      ST_S_CMP: begin
        if (mem_rdata_i.frame < frame_q) begin
          lo_d = mid + CNT_W'(1);
        end else begin
          hi_d = mid;
        end
      end
      // fetch the entry at the lower bound or at the checked index
      ST_L_RD: begin
        mem_req_o.raddr = (func_q == FUNC_DUP) ? IDX_W'(idx_q) : lo_q[IDX_W-1:0];
      end
      ST_L_CHK: begin
        case (func_q)
          FUNC_ADD: begin
            if (hit) begin
              mem_req_o.we        = 1'b1;
              mem_req_o.waddr     = lo_q[IDX_W-1:0];
              mem_req_o.wdata     = '{frame: frame_q, cnt: cnt_inc};
            end else if (full) begin
              status_d = STATUS_FULL;
            end else begin
              ptr_d = used_q;
            end
          end
          FUNC_REMOVE: begin
            if (!hit) begin
              status_d = STATUS_ABSENT;
            end else if (cnt_dec != '0) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = lo_q[IDX_W-1:0];
              mem_req_o.wdata = '{frame: frame_q, cnt: cnt_dec};
            end else begin
              ptr_d = lo_q;
            end
          end
          FUNC_QUERY: begin
            if (!hit) begin
              status_d = STATUS_ABSENT;
            end
          end
          default: begin
            if (idx_in) begin
              mult_d = (mem_rdata_i.cnt > COUNT_BITS'(1));
            end else begin
              status_d = STATUS_RANGE;
            end
          end
        endcase
      end
      // move entries up one place, then drop the new entry in
      ST_UP_RD: begin
        if (ptr_q > lo_q) begin
          mem_req_o.raddr = ptr_dec[IDX_W-1:0];
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = lo_q[IDX_W-1:0];
          mem_req_o.wdata = '{frame: frame_q, cnt: COUNT_BITS'(1)};
          used_d          = used_q + CNT_W'(1);
        end
      end
      ST_UP_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q[IDX_W-1:0];
        mem_req_o.wdata = mem_rdata_i;
        ptr_d           = ptr_dec;
      end
      // move later entries down one place over the deleted one
      ST_DN_RD: begin
        if (ptr_inc < used_q) begin
          mem_req_o.raddr = ptr_inc[IDX_W-1:0];
        end else begin
          used_d = used_q - CNT_W'(1);
        end
      end
      ST_DN_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q[IDX_W-1:0];
        mem_req_o.wdata = mem_rdata_i;
        ptr_d           = ptr_inc;
      end
      default: begin
      end
    endcase
  end

  // handshake and result fields
  always_comb begin
    in_stall_o        = (state_q != ST_IDLE);
    res_valid_o       = (state_q == ST_DONE);
    res_o             = '0;
    res_o.status      = status_q;
    res_o.entry_count = OUT_CNT_W'(used_q);
    res_o.multiple    = mult_q;
    res_o.found       = (func_q != FUNC_DUP) && (status_q == STATUS_OK);
    if (res_o.found) begin
      res_o.found_index = OUT_IDX_W'(lo_q);
    end
    if (func_q == FUNC_QUERY) begin
      if (lo_q != '0) begin
        res_o.prev_valid = 1'b1;
        res_o.prev_index = OUT_IDX_W'(lo_dec);
      end
      if (status_q == STATUS_OK) begin
        if (lo_inc < used_q) begin
          res_o.next_valid = 1'b1;
          res_o.next_index = OUT_IDX_W'(lo_inc);
        end
      end else if (lo_q < used_q) begin
        res_o.next_valid = 1'b1;
        res_o.next_index = OUT_IDX_W'(lo_q);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  // operation registers
  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    frame_q  <= frame_d;
    idx_q    <= idx_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    ptr_q    <= ptr_d;
    status_q <= status_d;
    mult_q   <= mult_d;
  end

  // the table never holds more than its depth
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // one operation adds or deletes at most one entry
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |->
      (used_q == $past(used_q) + CNT_W'(1) || used_q == $past(used_q) - CNT_W'(1)))
    else $error("entry count jumped");

  // search window stays inside the used part of the table
  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_S_CMP) |-> (lo_q < hi_q && hi_q <= used_q))
    else $error("search window out of range");

  // memory is written only in the update and shift states
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (state_q == ST_L_CHK || state_q == ST_UP_RD ||
                      state_q == ST_UP_WR || state_q == ST_DN_WR))
    else $error("memory write outside update states");

  // a finished result waits until the output stage takes it
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !res_take_i) |=> (state_q == ST_DONE && $stable(res_o)))
    else $error("result dropped before transfer");

endmodule

FILE: hw/rtl/sorted_frame_bucket_table.sv
`timescale 1ns / 1ps

// Sorted table of distinct frame numbers, each with a saturating key count.
// Input channel (in_valid_i / in_stall_o) carries func, frame and entry
// index; a transfer happens at a clock edge with valid high and stall low.
// Output channel (out_valid_o / out_stall_i) returns one result per item.
// Items are handled one at a time by a sequencer around a single table
// memory with one write and one registered read port. A lookup is a binary
// search with a read state and a compare state per step; the duplicate
// check skips the search and reads the entry at the given index.
// Insert and delete move entries one memory read and one write at a time.
// The result sits in an output register: a new item is taken while it
// waits for the receiver, and a stalled result holds its value. If a second
// result is finished while the first is still stalled, the sequencer waits.
// Reset empties the table (entry count 0); memory contents are not cleared
// and no clearing pass is needed.

module sorted_frame_bucket_table (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [sfbt_pkg::FUNC_W-1:0]          func_i,
  input  logic signed [sfbt_pkg::FRAME_W-1:0]  frame_i,
  input  logic [sfbt_pkg::OUT_IDX_W-1:0]       entry_index_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 found_o,
  output logic [sfbt_pkg::OUT_IDX_W-1:0]       found_index_o,
  output logic                                 prev_valid_o,
  output logic [sfbt_pkg::OUT_IDX_W-1:0]       prev_index_o,
  output logic                                 next_valid_o,
  output logic [sfbt_pkg::OUT_IDX_W-1:0]       next_index_o,
  output logic                                 multiple_o,
  output logic [1:0]                           status_o,
  output logic [sfbt_pkg::OUT_CNT_W-1:0]       entry_count_o
);

  import sfbt_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rdata;
  result_t  res;
  logic     res_valid;
  logic     res_take;
  logic     out_valid_q, out_valid_d;
  result_t  out_res_q;

  // table storage
  sfbt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // search and shift sequencer
  sfbt_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_e'(func_i)),
    .frame_i       (frame_i),
    .entry_index_i (entry_index_i),
    .res_valid_o   (res_valid),
    .res_take_i    (res_take),
    .res_o         (res),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

  // output register loads when empty or when its result transfers
  always_comb begin
    res_take    = res_valid && (!out_valid_q || !out_stall_i);
    out_valid_d = res_take || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_res_q.found;
  assign found_index_o = out_res_q.found_index;
  assign prev_valid_o  = out_res_q.prev_valid;
  assign prev_index_o  = out_res_q.prev_index;
  assign next_valid_o  = out_res_q.next_valid;
  assign next_index_o  = out_res_q.next_index;
  assign multiple_o    = out_res_q.multiple;
  assign status_o      = out_res_q.status;
  assign entry_count_o = out_res_q.entry_count;

endmodule

FILE: tb/sorted_frame_bucket_table_tb.sv
`timescale 1ns / 1ps

module sorted_frame_bucket_table_tb;
  import sfbt_pkg::*;

  localparam int NUM_ROWS  = 20;
  localparam int POOL_SIZE = 16;
  localparam int TAIL_CYCLES = 600;
  localparam result_t NO_RES = '0;

  // one row of the directed stimulus table
  typedef struct {
    func_e                     fn;
    logic signed [FRAME_W-1:0] fr;
    logic [OUT_IDX_W-1:0]      ix;
    bit                        typed;
    result_t                   res;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [FUNC_W-1:0]           func = FUNC_ADD;
  logic signed [FRAME_W-1:0]   frame = '0;
  logic [OUT_IDX_W-1:0]        entry_index = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        found;
  logic [OUT_IDX_W-1:0]        found_index;
  logic                        prev_valid;
  logic [OUT_IDX_W-1:0]        prev_index;
  logic                        next_valid;
  logic [OUT_IDX_W-1:0]        next_index;
  logic                        multiple;
  logic [1:0]                  status;
  logic [OUT_CNT_W-1:0]        entry_count;

  // shadow copy of the table
  logic signed [FRAME_W-1:0] tbl_frame [TABLE_DEPTH];
  logic [COUNT_BITS-1:0]     tbl_cnt [TABLE_DEPTH];
  int                        tbl_used = 0;

  result_t                   pending_results [$];
  result_t                   want_res;
  stim_row_t                 dir_rows [NUM_ROWS];
  logic signed [FRAME_W-1:0] frame_pool [POOL_SIZE];
  int                        n_fail = 0;
  int                        send_idle_pct = 0;
  int                        recv_idle_pct = 0;

  sorted_frame_bucket_table i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (func),
    .frame_i       (frame),
    .entry_index_i (entry_index),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .found_o       (found),
    .found_index_o (found_index),
    .prev_valid_o  (prev_valid),
    .prev_index_o  (prev_index),
    .next_valid_o  (next_valid),
    .next_index_o  (next_index),
    .multiple_o    (multiple),
    .status_o      (status),
    .entry_count_o (entry_count)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  function automatic result_t res_of(bit fnd, int fi, bit pv, int pi, bit nv, int ni,
                                     bit mult, status_e st, int cnt);
    result_t r;
    r.found       = fnd;
    r.found_index = OUT_IDX_W'(fi);
    r.prev_valid  = pv;
    r.prev_index  = OUT_IDX_W'(pi);
    r.next_valid  = nv;
    r.next_index  = OUT_IDX_W'(ni);
    r.multiple    = mult;
    r.status      = st;
    r.entry_count = OUT_CNT_W'(cnt);
    return r;
  endfunction

  // table update and result for one transfer
  function automatic result_t table_step(func_e fn, logic signed [FRAME_W-1:0] fr,
                                         logic [OUT_IDX_W-1:0] ix);
    result_t r;
    int      lb;
    int      k;
    bit      hit;
    r = '0;
    lb = 0;
    while (lb < tbl_used && tbl_frame[lb] < fr) lb++;
    hit = (lb < tbl_used) && (tbl_frame[lb] == fr);
    case (fn)
      FUNC_ADD: begin
        if (hit) begin
          if (tbl_cnt[lb] != COUNT_MAX) tbl_cnt[lb]++;
          r.found = 1'b1;
          r.found_index = OUT_IDX_W'(lb);
        end else if (tbl_used >= int'(TABLE_DEPTH)) begin
          r.status = STATUS_FULL;
        end else begin
          // open a slot at the lower bound
          for (k = tbl_used; k > lb; k--) begin
            tbl_frame[k] = tbl_frame[k-1];
            tbl_cnt[k]   = tbl_cnt[k-1];
          end
          tbl_frame[lb] = fr;
          tbl_cnt[lb]   = COUNT_BITS'(1);
          tbl_used++;
          r.found = 1'b1;
          r.found_index = OUT_IDX_W'(lb);
        end
      end
      FUNC_REMOVE: begin
        if (hit) begin
          r.found = 1'b1;
          r.found_index = OUT_IDX_W'(lb);
          if (tbl_cnt[lb] != 0) tbl_cnt[lb]--;
          if (tbl_cnt[lb] == 0) begin
            // close the gap
            for (k = lb; k + 1 < tbl_used; k++) begin
              tbl_frame[k] = tbl_frame[k+1];
              tbl_cnt[k]   = tbl_cnt[k+1];
            end
            tbl_used--;
          end
        end else begin
          r.status = STATUS_ABSENT;
        end
      end
      FUNC_QUERY: begin
        if (lb > 0) begin
          r.prev_valid = 1'b1;
          r.prev_index = OUT_IDX_W'(lb - 1);
        end
        if (hit) begin
          r.found = 1'b1;
          r.found_index = OUT_IDX_W'(lb);
          if (lb + 1 < tbl_used) begin
            r.next_valid = 1'b1;
            r.next_index = OUT_IDX_W'(lb + 1);
          end
        end else begin
          r.status = STATUS_ABSENT;
          if (lb < tbl_used) begin
            r.next_valid = 1'b1;
            r.next_index = OUT_IDX_W'(lb);
          end
        end
      end
      default: begin
        if (int'(ix) < tbl_used) r.multiple = (tbl_cnt[ix] > 1);
        else r.status = STATUS_RANGE;
      end
    endcase
    r.entry_count = OUT_CNT_W'(tbl_used);
    return r;
  endfunction

  // drive one item and hold it until the transfer
  task automatic send_item(input func_e fn, input logic signed [FRAME_W-1:0] fr,
                           input logic [OUT_IDX_W-1:0] ix, input bit typed,
                           input result_t typed_res);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= fn;
    frame       <= fr;
    entry_index <= ix;
    do @(posedge clk); while (in_stall);
    r = table_step(fn, fr, ix);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // mostly frames that can hit, some fully random
  function automatic logic signed [FRAME_W-1:0] pick_frame();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25 && tbl_used > 0) return tbl_frame[$urandom_range(tbl_used - 1)];
    if (sel < 88) return frame_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic random_item();
    func_e                fn;
    logic [OUT_IDX_W-1:0] ix;
    int                   sel;
    sel = $urandom_range(99);
    fn = (sel < 40) ? FUNC_ADD : (sel < 65) ? FUNC_REMOVE : (sel < 85) ? FUNC_QUERY : FUNC_DUP;
    ix = OUT_IDX_W'($urandom_range(255));
    if (fn == FUNC_DUP && tbl_used > 0 && $urandom_range(99) < 70)
      ix = OUT_IDX_W'($urandom_range(tbl_used - 1));
    send_item(fn, pick_frame(), ix, 1'b0, NO_RES);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      n_fail++;
    end
  endtask

  // result check and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending");
        n_fail++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("found", 32'(want_res.found), 32'(found));
        check_field("found_index", 32'(want_res.found_index), 32'(found_index));
        check_field("prev_valid", 32'(want_res.prev_valid), 32'(prev_valid));
        check_field("prev_index", 32'(want_res.prev_index), 32'(prev_index));
        check_field("next_valid", 32'(want_res.next_valid), 32'(next_valid));
        check_field("next_index", 32'(want_res.next_index), 32'(next_index));
        check_field("multiple", 32'(want_res.multiple), 32'(multiple));
        check_field("status", 32'(want_res.status), 32'(status));
        check_field("entry_count", 32'(want_res.entry_count), 32'(entry_count));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    int k;
    dir_rows = '{
      '{FUNC_DUP, 32'sd0, 8'd0, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, STATUS_RANGE, 0)},
      '{FUNC_QUERY, 32'sd0, 8'd0, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, STATUS_ABSENT, 0)},
      '{FUNC_REMOVE, 32'sd5, 8'd0, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, STATUS_ABSENT, 0)},
      '{FUNC_ADD, 32'sh7fff_ffff, 8'd0, 1'b1, res_of(1, 0, 0, 0, 0, 0, 0, STATUS_OK, 1)},
      '{FUNC_ADD, 32'sh8000_0000, 8'd0, 1'b1, res_of(1, 0, 0, 0, 0, 0, 0, STATUS_OK, 2)},
      '{FUNC_ADD, 32'sd0, 8'hff, 1'b0, NO_RES},
      '{FUNC_ADD, 32'sd0, 8'd0, 1'b0, NO_RES},
      '{FUNC_DUP, 32'sd0, 8'd1, 1'b0, NO_RES},
      '{FUNC_DUP, 32'shffff_ffff, 8'd0, 1'b0, NO_RES},
      '{FUNC_DUP, 32'sd0, 8'd255, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, STATUS_RANGE, 3)},
      '{FUNC_QUERY, 32'sd0, 8'd0, 1'b0, NO_RES},
      '{FUNC_QUERY, -32'sd1, 8'd0, 1'b0, NO_RES},
      '{FUNC_QUERY, 32'sh8000_0000, 8'd0, 1'b0, NO_RES},
      '{FUNC_QUERY, 32'sh7fff_ffff, 8'd0, 1'b0, NO_RES},
      '{FUNC_REMOVE, 32'sd0, 8'd0, 1'b0, NO_RES},
      '{FUNC_REMOVE, 32'sd0, 8'd0, 1'b0, NO_RES},
      '{FUNC_REMOVE, 32'sh7fff_ffff, 8'd0, 1'b0, NO_RES},
      '{FUNC_QUERY, 32'sd12345, 8'd0, 1'b0, NO_RES},
      '{FUNC_REMOVE, 32'sh8000_0000, 8'd0, 1'b1, res_of(1, 0, 0, 0, 0, 0, 0, STATUS_OK, 0)},
      '{FUNC_DUP, 32'sd0, 8'd0, 1'b1, res_of(0, 0, 0, 0, 0, 0, 0, STATUS_RANGE, 0)}
    };
    // small set of frames so that keys pile up on the same entries
    frame_pool[0] = 32'sh8000_0000;
    frame_pool[1] = 32'sh7fff_ffff;
    frame_pool[2] = 32'sd0;
    frame_pool[3] = -32'sd1;
    for (k = 4; k < POOL_SIZE; k++) frame_pool[k] = $urandom;

    send_idle_pct = 23;
    recv_idle_pct = 86;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (k = 0; k < NUM_ROWS; k++)
      send_item(dir_rows[k].fn, dir_rows[k].fr, dir_rows[k].ix, dir_rows[k].typed,
                dir_rows[k].res);
    repeat (40) random_item();
    drain_results();

    send_idle_pct = 86;
    recv_idle_pct = 23;
    // count saturation on one frame
    repeat (257) send_item(FUNC_ADD, 32'sd42, 8'd0, 1'b0, NO_RES);
    send_item(FUNC_DUP, 32'sd0, 8'd0, 1'b0, NO_RES);
    send_item(FUNC_REMOVE, 32'sd42, 8'd0, 1'b0, NO_RES);
    // fill the table to the top
    for (k = 0; k < int'(TABLE_DEPTH) - 1; k++)
      send_item(FUNC_ADD, FRAME_W'(1000 + k), 8'd0, 1'b0, NO_RES);
    send_item(FUNC_ADD, 32'sd5000, 8'd0, 1'b1,
              res_of(0, 0, 0, 0, 0, 0, 0, STATUS_FULL, TABLE_DEPTH));
    send_item(FUNC_ADD, 32'sh8000_0000, 8'd0, 1'b0, NO_RES);
    send_item(FUNC_ADD, 32'sd42, 8'd0, 1'b0, NO_RES);
    send_item(FUNC_ADD, 32'sd42, 8'd0, 1'b0, NO_RES);
    send_item(FUNC_DUP, 32'sd0, 8'd255, 1'b0, NO_RES);
    send_item(FUNC_QUERY, 32'sh7fff_ffff, 8'd0, 1'b0, NO_RES);
    send_item(FUNC_REMOVE, 32'sd1000, 8'd0, 1'b0, NO_RES);
    send_item(FUNC_ADD, -32'sd7, 8'd0, 1'b0, NO_RES);
    send_item(FUNC_ADD, 32'sd3, 8'd0, 1'b0, NO_RES);
    repeat (20) random_item();
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (40) random_item();
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sorted_frame_bucket_table.f
hw/rtl/sfbt_pkg.sv
hw/rtl/sfbt_ram.sv
hw/rtl/sfbt_seq.sv
hw/rtl/sorted_frame_bucket_table.sv
tb/sorted_frame_bucket_table_tb.sv
